FILE: hdl/fdlh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlh_pkg - shared definitions for the Hermite fractional delay line
// Default sizes, field widths, item kinds and the back-end state type.
// ----------------------------------------------------------------------------
package fdlh_pkg;

    // default sizes for the top-level parameters
    localparam int DEPTH_DEF       = 65536;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int DELAY_W = 32;   // delay request field
    localparam int LEN_W   = 17;   // line length register

    // line length after reset
    localparam int LEN_RESET = 65536;

    // items queued between front and back end
    localparam int QUEUE_DEPTH = 2;

    // item kinds (mode field)
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FETCH,
        BK_PREP,
        BK_MUL,
        BK_DONE
    } fdlh_bk_state_t;

endpackage

FILE: hdl/fractional_delay_line_hermite.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_line_hermite - audio delay line, 4-point Hermite readout
// Circular sample store with write requests and fractional-delay reads.
// ----------------------------------------------------------------------------
// A write request (tuser = 0) advances the write pointer, wrapping at the
// configured line length, and stores tdata's sample there; it returns nothing.
// A read request (tuser = 1) carries a delay in samples with FRAC_BITS
// fraction bits, clamped to 1 .. length-2, fetches the four samples around it
// and returns their cubic Hermite interpolation, saturated to SAMPLE_BITS.
// Sequence: after reset the store is cleared one entry per cycle, with
// s_axis_tready low; configuration is taken anyway. Afterwards a write is
// stored as it is dequeued; a read is dequeued, reads the four taps through
// the single memory port, forms the tap differences, evaluates the cubic in
// Horner steps through the shared multiplier and, once the output is free,
// loads the result register. A two-entry queue lets the intake keep taking
// requests while the back end works or while a result waits to be taken.
// The line length register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module fractional_delay_line_hermite #(
    parameter int DEPTH       = fdlh_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = fdlh_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdlh_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    // line length, clamped to 3 .. DEPTH internally
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fdlh_pkg::LEN_W-1:0]  cfg_data,

    // request stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // tdata: sample_in [SAMPLE_BITS], delay_amount [32], zero pad to bytes
    input  logic [((SAMPLE_BITS + fdlh_pkg::DELAY_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: mode (0 write, 1 read)
    input  logic [0:0] s_axis_tuser,

    // result stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tdata: sample_out [SAMPLE_BITS], zero pad to bytes
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import fdlh_pkg::*;

    localparam int PTR_W    = $clog2(DEPTH);
    localparam int LEN_EW   = $clog2(DEPTH + 1);
    localparam int ENT_W    = 1 + SAMPLE_BITS + PTR_W + FRAC_BITS;
    localparam int CFG_CW   = (LEN_EW > LEN_W) ? LEN_EW : LEN_W;
    localparam int LEN_INIT = (LEN_RESET > DEPTH) ? DEPTH : LEN_RESET;
    localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;

    // effective (already clamped) line length
    logic [LEN_EW-1:0]      len_reg, len_next;
    logic [CFG_CW-1:0]      cfg_ext;

    logic                   clearing;
    logic                   q_push, q_full, q_pop, q_empty;
    logic [ENT_W-1:0]       q_push_data, q_pop_data;
    logic [SAMPLE_BITS-1:0] out_sample;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_ext  = CFG_CW'(cfg_data);
        len_next = len_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_ext < CFG_CW'(3))
            begin
                len_next = LEN_EW'(3);
            end
            else if (cfg_ext > CFG_CW'(DEPTH))
            begin
                len_next = LEN_EW'(DEPTH);
            end
            else
            begin
                len_next = cfg_ext[LEN_EW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_EW'(LEN_INIT);
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // intake: holds one request, owns the write pointer, resolves addresses
    fdlh_front #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .LEN_EW      (LEN_EW),
        .ENT_W       (ENT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser[0]),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_delay  (s_axis_tdata[SAMPLE_BITS +: DELAY_W]),
        .len       (len_reg),
        .clearing  (clearing),
        .q_push    (q_push),
        .q_data    (q_push_data),
        .q_full    (q_full)
    );

    fdlh_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // store, fetch and interpolation
    fdlh_back #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .LEN_EW      (LEN_EW),
        .ENT_W       (ENT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .len        (len_reg),
        .q_empty    (q_empty),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .clearing   (clearing),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_sample (out_sample)
    );

    assign m_axis_tdata = OUT_W'(out_sample);

`ifndef NO_ASSERTIONS
    // no request enters while the store is being cleared
    a_no_take_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> !s_axis_tready
    ) else $error("request taken during clearing sweep");

    // the command queue never overflows
    a_queue_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_push |-> (!q_full || q_pop)
    ) else $error("command queue overflow");

    // the back end only dequeues real commands
    a_queue_no_underflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty
    ) else $error("command queue underflow");

    // effective line length stays within 3 .. DEPTH
    a_len_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (len_reg >= LEN_EW'(3)) && (len_reg <= LEN_EW'(DEPTH))
    ) else $error("line length out of range");
`endif

endmodule

FILE: hdl/fdlh_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlh_queue - short command queue between front and back end
// Register-based FIFO, QUEUE_DEPTH entries of WIDTH bits.
// ----------------------------------------------------------------------------
module fdlh_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import fdlh_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/fdlh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlh_front - request intake for the Hermite delay line
// Holds one request, owns the write pointer, clamps the delay and turns each
// request into a store command or a fetch command with its start address.
// ----------------------------------------------------------------------------
module fdlh_front #(
    parameter int DEPTH       = fdlh_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = fdlh_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdlh_pkg::FRAC_BITS_DEF,
    parameter int LEN_EW      = $clog2(DEPTH + 1),
    parameter int ENT_W       = 1 + SAMPLE_BITS + $clog2(DEPTH) + FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_mode,
    input  logic [SAMPLE_BITS-1:0]      in_sample,
    input  logic [fdlh_pkg::DELAY_W-1:0] in_delay,
    input  logic [LEN_EW-1:0]           len,
    input  logic                        clearing,
    output logic                        q_push,
    output logic [ENT_W-1:0]            q_data,
    input  logic                        q_full
);
    import fdlh_pkg::*;

    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CMP_W    = (DELAY_W > LEN_EW + FRAC_BITS) ? DELAY_W : LEN_EW + FRAC_BITS;
    localparam int LEN_INIT = (LEN_RESET > DEPTH) ? DEPTH : LEN_RESET;
    localparam int IA_W     = LEN_EW + 2;

    logic                   hold_valid_reg, hold_valid_next;
    logic                   hold_mode_reg;
    logic [SAMPLE_BITS-1:0] hold_sample_reg;
    logic [DELAY_W-1:0]     hold_delay_reg;
    logic [PTR_W-1:0]       wp_reg, wp_next;

    logic                   take;
    logic                   is_read;
    logic [CMP_W-1:0]       d_ext, d_lo, d_hi, d_cl;
    logic [LEN_EW-1:0]      idel;
    logic [FRAC_BITS-1:0]   frac;
    logic [IA_W-1:0]        ia_raw, ia_fix;
    logic [LEN_EW-1:0]      wp_inc;
    logic [PTR_W-1:0]       wp_wrap;

    assign is_read  = (hold_mode_reg == MODE_READ);
    assign q_push   = hold_valid_reg && !q_full;
    assign in_ready = !clearing && (!hold_valid_reg || q_push);
    assign take     = in_valid && in_ready;

    // delay clamp to 1 .. len-2
    always_comb
    begin
        d_ext = CMP_W'(hold_delay_reg);
        d_lo  = CMP_W'(1) << FRAC_BITS;
        d_hi  = CMP_W'(len - LEN_EW'(2)) << FRAC_BITS;
        if (d_ext < d_lo)
        begin
            d_cl = d_lo;
        end
        else if (d_ext > d_hi)
        begin
            d_cl = d_hi;
        end
        else
        begin
            d_cl = d_ext;
        end
        idel = d_cl[FRAC_BITS +: LEN_EW];
        frac = d_cl[FRAC_BITS-1:0];
    end

    // newest of the four taps: wp + 1 - delay, wrapped once by len
    always_comb
    begin
        ia_raw = IA_W'(wp_reg) + IA_W'(1) - IA_W'(idel);
        ia_fix = ia_raw[IA_W-1] ? ia_raw + IA_W'(len) : ia_raw;
    end

    always_comb
    begin
        wp_inc  = LEN_EW'(wp_reg) + LEN_EW'(1);
        wp_wrap = (wp_inc >= len) ? '0 : wp_inc[PTR_W-1:0];
    end

    always_comb
    begin
        if (is_read)
        begin
            q_data = {MODE_READ, {SAMPLE_BITS{1'b0}}, ia_fix[PTR_W-1:0], frac};
        end
        else
        begin
            q_data = {MODE_WRITE, hold_sample_reg, wp_wrap, {FRAC_BITS{1'b0}}};
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
        wp_next = (q_push && !is_read) ? wp_wrap : wp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            wp_reg         <= PTR_W'(LEN_INIT - 1);
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            wp_reg         <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_mode_reg   <= in_mode;
            hold_sample_reg <= in_sample;
            hold_delay_reg  <= in_delay;
        end
    end

endmodule

FILE: hdl/fdlh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdlh_back - sample store and Hermite interpolator
// Single-port sample memory with a clearing sweep after reset, four-tap fetch
// and a shared multiplier that evaluates the cubic in three Horner steps.
// ----------------------------------------------------------------------------
module fdlh_back #(
    parameter int DEPTH       = fdlh_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = fdlh_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdlh_pkg::FRAC_BITS_DEF,
    parameter int LEN_EW      = $clog2(DEPTH + 1),
    parameter int ENT_W       = 1 + SAMPLE_BITS + $clog2(DEPTH) + FRAC_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [LEN_EW-1:0]      len,
    input  logic                   q_empty,
    input  logic [ENT_W-1:0]       q_data,
    output logic                   q_pop,
    output logic                   clearing,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SAMPLE_BITS-1:0] out_sample
);
    import fdlh_pkg::*;

    localparam int PTR_W      = $clog2(DEPTH);
    localparam int S          = SAMPLE_BITS;
    localparam int W          = SAMPLE_BITS + 5;   // holds every Horner term
    localparam int CNT_W      = 3;
    localparam int FETCH_LAST = 4;
    localparam int MUL_LAST   = 2;

    localparam logic signed [W-1:0] SAT_MAX = {{(W-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {{(W-S+1){1'b1}}, {(S-1){1'b0}}};

    fdlh_bk_state_t state_reg, state_next;

    // memory
    logic [S-1:0]     mem [DEPTH];
    logic [S-1:0]     rd_reg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_addr;
    logic [S-1:0]     mem_wdata;

    // queue entry fields
    logic                 ent_read;
    logic [S-1:0]         ent_sample;
    logic [PTR_W-1:0]     ent_addr;
    logic [FRAC_BITS-1:0] ent_frac;

    logic [PTR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [PTR_W-1:0]     addr_reg, addr_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]           step_reg, step_next;

    logic signed [S-1:0]   smp_a_reg, smp_b_reg, smp_c_reg, smp_d_reg;
    logic                  shift_en;
    logic signed [S+2:0]   a_reg, a_next;
    logic signed [S+3:0]   b_reg, b_next;
    logic signed [S:0]     s0_reg, s0_next;
    logic signed [S:0]     bb_reg, bb_next;
    logic signed [W-1:0]   t_reg, t_next;
    logic                  out_valid_reg, out_valid_next;
    logic [S-1:0]          out_sample_reg, out_sample_next;

    logic signed [W-1:0]           ea, eb, ec, ed, s0, s1, v, w, aa, bv;
    logic signed [W-1:0]           mul_op, addend, sh, r_full;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [W+FRAC_BITS:0]   prod;
    logic                          out_free;

    assign {ent_read, ent_sample, ent_addr, ent_frac} = q_data;
    assign clearing   = (state_reg == BK_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                if (clr_addr_reg == PTR_W'(DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_empty && (ent_read == MODE_READ))
                begin
                    state_next = BK_FETCH;
                end
            end
            BK_FETCH:
            begin
                if (cnt_reg == CNT_W'(FETCH_LAST))
                begin
                    state_next = BK_PREP;
                end
            end
            BK_PREP:
            begin
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                if (step_reg == 2'(MUL_LAST))
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // state outputs: memory port, queue pop, capture enable
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = ent_sample;
        q_pop     = 1'b0;
        shift_en  = 1'b0;
        case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = '0;
            end
            BK_IDLE:
            begin
                mem_addr = ent_addr;
                if (!q_empty)
                begin
                    q_pop  = 1'b1;
                    mem_we = (ent_read == MODE_WRITE);
                end
            end
            BK_FETCH:
            begin
                shift_en = (cnt_reg != '0);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // tap differences, all at twice the sample scale
    always_comb
    begin
        ea = W'(smp_a_reg);
        eb = W'(smp_b_reg);
        ec = W'(smp_c_reg);
        ed = W'(smp_d_reg);
        s0 = ec - ea;
        s1 = ed - eb;
        v  = (eb - ec) <<< 1;
        w  = s0 + v;
        aa = w + v + s1;
        bv = w + aa;
    end

    // shared multiplier, one Horner step per cycle
    always_comb
    begin
        mul_op = (step_reg == 2'd0) ? W'(a_reg) : t_reg;
        frac_s = $signed({1'b0, frac_reg});
        prod   = mul_op * frac_s;
        sh     = $signed(prod[FRAC_BITS +: W]);
        case (step_reg)
            2'd0:    addend = -W'(b_reg);
            2'd1:    addend = W'(s0_reg);
            default: addend = W'(bb_reg);
        endcase
        r_full = t_reg >>> 1;
    end

    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        addr_next       = addr_reg;
        frac_next       = frac_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        s0_next         = s0_reg;
        bb_next         = bb_reg;
        t_next          = t_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sample_next = out_sample_reg;
        case (state_reg)
            BK_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            BK_IDLE:
            begin
                addr_next = ent_addr;
                frac_next = ent_frac;
                cnt_next  = '0;
            end
            BK_FETCH:
            begin
                // walk toward older samples, wrapping below zero to len-1
                addr_next = (addr_reg == '0) ? PTR_W'(len - LEN_EW'(1)) : addr_reg - 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            BK_PREP:
            begin
                a_next    = aa[S+2:0];
                b_next    = bv[S+3:0];
                s0_next   = s0[S:0];
                bb_next   = {smp_b_reg, 1'b0};
                step_next = '0;
            end
            BK_MUL:
            begin
                t_next    = sh + addend;
                step_next = step_reg + 1'b1;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (r_full > SAT_MAX)
                    begin
                        out_sample_next = SAT_MAX[S-1:0];
                    end
                    else if (r_full < SAT_MIN)
                    begin
                        out_sample_next = SAT_MIN[S-1:0];
                    end
                    else
                    begin
                        out_sample_next = r_full[S-1:0];
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        frac_reg       <= frac_next;
        cnt_reg        <= cnt_next;
        step_reg       <= step_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        s0_reg         <= s0_next;
        bb_reg         <= bb_next;
        t_reg          <= t_next;
        out_sample_reg <= out_sample_next;
        if (shift_en)
        begin
            smp_a_reg <= smp_b_reg;
            smp_b_reg <= smp_c_reg;
            smp_c_reg <= smp_d_reg;
            smp_d_reg <= rd_reg;
        end
    end

    // single-port sample store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        else
        begin
            rd_reg <= mem[mem_addr];
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the Hermite fractional delay line
// Drives write and read requests with random gaps and output stalls, predicts
// every interpolated sample from a local copy of the store and pointer, and
// walks the line length through its extremes between drained phases.
// ----------------------------------------------------------------------------
module tb;
    import fdlh_pkg::*;

    localparam int SW       = SAMPLE_BITS_DEF;
    localparam int FW       = FRAC_BITS_DEF;
    localparam int TDATA_W  = ((SW + DELAY_W + 7) / 8) * 8;
    localparam int RDATA_W  = ((SW + 7) / 8) * 8;

    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    // cycles with no handshake anywhere before giving up; covers the
    // store clear after reset with margin
    localparam int IDLE_LIMIT = 300000;
    // long output hold that backs the block up into its input
    localparam int LONG_HOLD  = 150;
    // settle time after a drain: queued writes still go through the back end
    localparam int SETTLE     = 20;

    typedef struct packed {
        logic              mode;
        logic [SW-1:0]     sample;
        logic [DELAY_W-1:0] delay;
    } dl_request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data = '0;

    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // tdata: sample_in [23:0], delay_amount [55:24]
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    // tuser: mode
    logic [0:0]         s_axis_tuser = '0;

    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // tdata: sample_out [23:0]
    logic [RDATA_W-1:0] m_axis_tdata;

    fractional_delay_line_hermite uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the sample store, pointer and length
    // ------------------------------------------------------------------------
    logic signed [SW-1:0] line_store [DEPTH_DEF];
    int unsigned          wr_ptr;
    logic [LEN_W-1:0]     line_len_q;

    dl_request_t          pending_reqs[$];      // requests not yet offered
    logic [SW-1:0]        expected_samples[$];  // interpolations still owed

    dl_request_t cur_req;
    int          gap_left;
    int          stall_left;
    bit          steady_flow;   // phase with no idling on either side
    bit          hold_armed;
    bit          hold_done;

    int mismatch_count;
    int results_checked;
    int writes_sent;
    int reads_sent;
    int settings_used;
    int idle_cycles;

    // line length as the block uses it: clamped to 3 .. DEPTH
    function automatic int unsigned clamp_length(logic [LEN_W-1:0] value);
        int unsigned n;
        n = value;
        if (n < 3)
            n = 3;
        if (n > DEPTH_DEF)
            n = DEPTH_DEF;
        return n;
    endfunction

    // store tap; a negative index wraps once by the line length
    function automatic longint store_tap(longint idx, int unsigned len);
        longint k;
        k = idx;
        if (k < 0)
            k += len;
        if (k < 0)
            k = 0;
        return longint'(line_store[k % DEPTH_DEF]);
    endfunction

    // 4-point Hermite at twice the sample scale, floor after each product
    function automatic logic [SW-1:0] hermite_sample(logic [DELAY_W-1:0] delay);
        int unsigned len;
        longint d, lo, hi, idel, f, ia;
        longint sa, sb, sc, sd, s0, s1, v, w, a, b, t1, t2, t3, r;
        len  = clamp_length(line_len_q);
        lo   = longint'(1) << FW;
        hi   = longint'(len - 2) << FW;
        d    = delay;
        if (d < lo)
            d = lo;
        if (d > hi)
            d = hi;
        idel = d >>> FW;
        f    = d & (lo - 1);
        ia   = longint'(wr_ptr) - idel + 1;
        sa   = store_tap(ia, len);
        sb   = store_tap(ia - 1, len);
        sc   = store_tap(ia - 2, len);
        sd   = store_tap(ia - 3, len);
        s0   = sc - sa;
        s1   = sd - sb;
        v    = 2 * (sb - sc);
        w    = s0 + v;
        a    = w + v + s1;
        b    = w + a;
        t1   = ((a * f) >>> FW) - b;
        t2   = ((t1 * f) >>> FW) + s0;
        t3   = ((t2 * f) >>> FW) + 2 * sb;
        r    = t3 >>> 1;
        if (r > longint'(SMAX))
            r = longint'(SMAX);
        if (r < longint'(SMIN))
            r = longint'(SMIN);
        return r[SW-1:0];
    endfunction

    // advance the pointer and store on a write, or owe one sample on a read
    task automatic apply_request(dl_request_t req);
        int unsigned nxt;
        if (req.mode == MODE_WRITE) begin
            nxt = wr_ptr + 1;
            if (nxt >= clamp_length(line_len_q))
                nxt = 0;
            wr_ptr = nxt;
            line_store[wr_ptr % DEPTH_DEF] = req.sample;
            writes_sent++;
        end
        else begin
            expected_samples.push_back(hermite_sample(req.delay));
            reads_sent++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("tb: MISMATCH at %0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: watchdog, no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: pops pending requests, random gap after each one outside
    // steady phases. The predictor runs at the edge where a request is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_request(cur_req);
                gap_left = steady_flow ? 0 : $urandom_range(4, 0);
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // request still on offer, hold it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                cur_req = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= TDATA_W'({cur_req.delay, cur_req.sample});
                s_axis_tuser  <= cur_req.mode;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks against the oldest owed sample, then draws a
    // stall. Once armed, one long hold lets the block fill and stall its input.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch($sformatf("result %0d (sample_out %0d) with none owed",
                        results_checked, $signed(m_axis_tdata[SW-1:0])));
                else if (m_axis_tdata[SW-1:0] !== expected_samples[0])
                    report_mismatch($sformatf("result %0d: sample_out %0d, want %0d",
                        results_checked, $signed(m_axis_tdata[SW-1:0]),
                        $signed(expected_samples[0])));
                if (expected_samples.size() > 0)
                    void'(expected_samples.pop_front());
                results_checked++;
                stall_left = steady_flow ? 0 : $urandom_range(4, 0);
            end
            if (hold_armed && !hold_done)
            begin
                stall_left = LONG_HOLD;
                hold_done  = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic dl_request_t make_req(logic mode, logic [SW-1:0] sample,
                                             logic [DELAY_W-1:0] delay);
        dl_request_t req;
        req.mode   = mode;
        req.sample = sample;
        req.delay  = delay;
        return req;
    endfunction

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(7, 0))
            0:       return SMAX;
            1:       return SMIN;
            2:       return '0;
            3:       return '1;
            default: return SW'($urandom);
        endcase
    endfunction

    // mostly short in-range delays so reads land on written samples;
    // the rest below, above, across the line or anywhere in the 32-bit field
    function automatic logic [DELAY_W-1:0] rand_delay(int unsigned len);
        int unsigned dmax;
        dmax = (len - 2 < 40) ? len - 2 : 40;
        case ($urandom_range(9, 0))
            0:       return $urandom;
            1:       return $urandom_range(32'h0000_FFFF, 0);
            2:       return ((len - 2) << FW) + $urandom_range(32'h0000_FFFF, 0);
            3:       return $urandom_range((len - 2) << FW, 1 << FW);
            default: return $urandom_range(dmax << FW, 1 << FW);
        endcase
    endfunction

    // wait until nothing is queued, on offer or owed
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_samples.size() != 0);
    endtask

    task automatic write_line_length(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        line_len_q = value;
        settings_used++;
    endtask

    // drain, settle, set a new length, then queue random requests
    task automatic run_phase(input logic [LEN_W-1:0] len_value, input int count,
                             input bit steady);
        int unsigned len;
        logic        mode;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_line_length(len_value);
        len = clamp_length(len_value);
        @(negedge clk);
        steady_flow = steady;
        for (int k = 0; k < count; k++)
        begin
            mode = ($urandom_range(99, 0) < 45) ? MODE_READ : MODE_WRITE;
            pending_reqs.push_back(make_req(mode, rand_sample(), rand_delay(len)));
        end
    endtask

    initial
    begin
        mismatch_count  = 0;
        results_checked = 0;
        writes_sent     = 0;
        reads_sent      = 0;
        settings_used   = 0;
        idle_cycles     = 0;
        steady_flow     = 1'b0;
        hold_armed      = 1'b0;
        hold_done       = 1'b0;
        foreach (line_store[k])
            line_store[k] = '0;
        line_len_q = LEN_W'(LEN_RESET);
        wr_ptr     = clamp_length(line_len_q) - 1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // full length, written while the store is still being cleared
        write_line_length(LEN_W'(DEPTH_DEF));
        @(negedge clk);

        // overshoot past full scale, upward then downward
        pending_reqs.push_back(make_req(MODE_WRITE, SMIN, '0));
        pending_reqs.push_back(make_req(MODE_WRITE, SMAX, '0));
        pending_reqs.push_back(make_req(MODE_WRITE, SMAX, '0));
        pending_reqs.push_back(make_req(MODE_WRITE, SMIN, '0));
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'h0001_8000));
        pending_reqs.push_back(make_req(MODE_WRITE, SMAX, '1));
        pending_reqs.push_back(make_req(MODE_WRITE, SMIN, '1));
        pending_reqs.push_back(make_req(MODE_WRITE, SMIN, '1));
        pending_reqs.push_back(make_req(MODE_WRITE, SMAX, '1));
        pending_reqs.push_back(make_req(MODE_READ, '1, 32'h0001_8000));
        // delay below one sample, exactly one, one plus nearly a whole step
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'h0000_0000));
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'h0001_0000));
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'h0001_FFFF));
        // oldest tap lands before index zero and wraps to the top
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'h0006_8000));
        // delay far past the line, clamped to length minus two
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(MODE_WRITE, '0, '0));
        pending_reqs.push_back(make_req(MODE_WRITE, '1, '1));
        pending_reqs.push_back(make_req(MODE_WRITE, 24'h2A_AAAA, 32'h5555_5555));
        pending_reqs.push_back(make_req(MODE_READ, 24'h55_5555, 32'h0002_4000));
        pending_reqs.push_back(make_req(MODE_READ, '0, 32'h0000_FFFF));

        // random phases; shrinking the length leaves the pointer past the end
        run_phase(LEN_W'(DEPTH_DEF), 80, 1'b0);
        run_phase(LEN_W'(3), 100, 1'b0);
        run_phase(LEN_W'(0), 40, 1'b0);
        run_phase(LEN_W'(16), 120, 1'b1);
        run_phase('1, 80, 1'b0);
        run_phase(LEN_W'(5), 100, 1'b0);
        run_phase(LEN_W'(100), 140, 1'b0);
        hold_armed = 1'b1;
        run_phase(LEN_W'(2), 20, 1'b0);
        run_phase(LEN_W'(DEPTH_DEF), 80, 1'b1);
        run_phase(LEN_W'(37), 80, 1'b0);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (expected_samples.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_samples.size()));

        $display("tb: %0d writes and %0d reads over %0d line lengths, %0d results checked",
                 writes_sent, reads_sent, settings_used, results_checked);
        $display("tb: output hold of %0d cycles %0s, %0d mismatches", LONG_HOLD,
                 hold_done ? "applied" : "not applied", mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
